>>> design/nusf_pkg.sv
`timescale 1ns / 1ps

package nusf_pkg;

    // Widths of the stream payload and of the configuration port.
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 13;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int FLAGS_W  = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [1:0]        t_status;
    typedef logic [FLAGS_W-1:0] t_flags;

    // Status codes reported on the last byte of a record.
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_MISMATCH = 2'd1;
    localparam t_status STATUS_BAD_HDR  = 2'd2;
    localparam t_status STATUS_UNSEEN   = 2'd3;

    // Bit positions in the per-record error flags.
    localparam int FLAG_MISMATCH = 0;
    localparam int FLAG_BAD_HDR  = 1;
    localparam int FLAG_UNSEEN   = 2;

    // Register index decoded from paddr.
    localparam logic REG_RECORD_SIZE = 1'b0;

    // Header layout of a record.
    localparam int HDR_OFFSET_LO = 4;
    localparam int HDR_OFFSET_HI = 5;
    localparam int HDR_COUNT_LO  = 6;
    localparam int HDR_COUNT_HI  = 7;
    localparam int HDR_BYTES     = 8;

    localparam logic [CFG_W-1:0] RECORD_SIZE_RESET = 13'd1024;
    localparam int MIN_RECORD_BYTES = 2;

endpackage

>>> design/nusf_in_if.sv
`timescale 1ns / 1ps

// Input byte channel.
interface nusf_in_if;
    logic           valid;
    logic           ready;
    nusf_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> design/nusf_out_if.sv
`timescale 1ns / 1ps

// Result byte channel.
interface nusf_out_if;
    logic              valid;
    logic              ready;
    nusf_pkg::t_byte   out_byte;
    logic              record_end;
    nusf_pkg::t_status status;

    modport source (output valid, output out_byte, output record_end, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input record_end, input status,
                    output ready);
endinterface

>>> design/ntfs_update_sequence_fixup_core.sv
`timescale 1ns / 1ps

// Undoes the NTFS update sequence fixup on a record streamed one byte per
// transaction. While the output register is empty or being drained, one byte
// is accepted per cycle and its fixed-up copy is written into that register;
// the input stalls while the register holds a byte the receiver has not taken.
// The record length comes from the record_size register (clamped to
// 2..MAX_RECORD_BYTES) and must only be written between records. Header bytes
// 4..7 give the fixup array offset and entry count; the last two bytes of every
// full SECTOR_BYTES sector that has an array entry are replaced by the saved
// array word; status (0 ok, 1 tail mismatch, 2 bad header, 3 fixup word not
// yet seen) is valid on the byte that carries record_end and is zero elsewhere.
module ntfs_update_sequence_fixup_core #(
    parameter int MAX_RECORD_BYTES = 4096,
    parameter int SECTOR_BYTES     = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nusf_in_if.sink                       i_data,
    nusf_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nusf_pkg::APB_AW-1:0]   paddr,
    input  logic [nusf_pkg::APB_DW-1:0]   pwdata,
    output logic [nusf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int PW         = $clog2(MAX_RECORD_BYTES);
    localparam int SW_RAW     = $clog2(MAX_RECORD_BYTES + 1);
    localparam int SW         = (SW_RAW > nusf_pkg::CFG_W) ? SW_RAW : nusf_pkg::CFG_W;
    localparam int CW         = ((SW > nusf_pkg::WORD_W) ? SW : nusf_pkg::WORD_W) + 2;
    localparam int SPW        = $clog2(SECTOR_BYTES);
    localparam int WORD_SLOTS = MAX_RECORD_BYTES / SECTOR_BYTES + 1;
    localparam int DATA_SLOTS = (WORD_SLOTS > 1) ? WORD_SLOTS - 1 : 1;
    localparam int SIW        = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int DIW        = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;

    // Configuration register.
    logic [nusf_pkg::CFG_W-1:0] r_record_size;

    // Per-record state.
    logic [PW-1:0]            r_pos,       n_pos;
    logic [SPW-1:0]           r_sec_pos,   n_sec_pos;
    logic [SIW-1:0]           r_sec_idx,   n_sec_idx;
    nusf_pkg::t_word          r_offset,    n_offset;
    nusf_pkg::t_word          r_count,     n_count;
    nusf_pkg::t_byte          r_hdr_lo,    n_hdr_lo;
    nusf_pkg::t_byte          r_held,      n_held;
    nusf_pkg::t_flags         r_flags,     n_flags;

    // Fixup array: the check word and one word per sector.
    nusf_pkg::t_word          r_check;
    nusf_pkg::t_word          r_words [DATA_SLOTS];

    // Output register.
    logic                     r_out_valid;
    nusf_pkg::t_byte          r_out_byte,  n_out_byte;
    logic                     r_out_end,   n_out_end;
    nusf_pkg::t_status        r_out_status, n_out_status;

    logic                     accept;
    logic                     cfg_wr;
    nusf_pkg::t_byte          in_byte;
    logic [SW-1:0]            cfg_ext;
    logic [SW-1:0]            size_used;
    logic [CW-1:0]            pos_w;
    logic [CW-1:0]            offset_w;
    logic [CW-1:0]            count_w;
    logic [CW-1:0]            size_w;
    logic [CW-1:0]            arr_dist;
    logic [CW-1:0]            word_k;
    logic [CW-1:0]            sec_start;
    logic [CW-1:0]            first_tail;
    logic [CW-1:0]            slot_w;
    nusf_pkg::t_word          hdr_word;
    nusf_pkg::t_word          tail_word;
    logic [DIW-1:0]           wr_idx;
    logic [DIW-1:0]           rd_idx;
    logic                     active;
    logic                     wr_check_lo, wr_check_hi;
    logic                     wr_data_lo,  wr_data_hi;
    logic                     in_tail, tail_fixed, tail_ready, rec_end;

    assign accept         = i_data.valid && i_data.ready;
    assign i_data.ready   = !r_out_valid || o_result.ready;
    assign in_byte        = i_data.data_byte;

    assign o_result.valid      = r_out_valid;
    assign o_result.out_byte   = r_out_byte;
    assign o_result.record_end = r_out_end;
    assign o_result.status     = r_out_status;

    // APB register access; writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[nusf_pkg::APB_AW-1] == nusf_pkg::REG_RECORD_SIZE);
    assign prdata = (paddr[nusf_pkg::APB_AW-1] == nusf_pkg::REG_RECORD_SIZE)
                    ? nusf_pkg::APB_DW'(r_record_size) : '0;

    // Clamp the configured record size to the supported range.
    always_comb begin
        cfg_ext = SW'(r_record_size);
        if (cfg_ext < SW'(nusf_pkg::MIN_RECORD_BYTES)) begin
            size_used = SW'(nusf_pkg::MIN_RECORD_BYTES);
        end else if (cfg_ext > SW'(MAX_RECORD_BYTES)) begin
            size_used = SW'(MAX_RECORD_BYTES);
        end else begin
            size_used = cfg_ext;
        end
    end

    // Position arithmetic in one common width, and the array word lookups.
    always_comb begin
        pos_w      = CW'(r_pos);
        offset_w   = CW'(r_offset);
        count_w    = CW'(r_count);
        size_w     = CW'(size_used);
        arr_dist   = pos_w - offset_w;
        word_k     = {1'b0, arr_dist[CW-1:1]};
        sec_start  = pos_w - CW'(r_sec_pos);
        first_tail = sec_start + CW'(SECTOR_BYTES - 2);
        slot_w     = CW'(r_sec_idx) + CW'(1);
        hdr_word   = {in_byte, r_hdr_lo};
        rd_idx     = r_sec_idx[DIW-1:0];
        tail_word  = r_words[rd_idx];
        wr_idx     = DIW'(word_k - CW'(1));
    end

    // Header parse, fixup word capture, tail replacement and end of record.
    always_comb begin
        n_pos        = r_pos;
        n_sec_pos    = r_sec_pos;
        n_sec_idx    = r_sec_idx;
        n_offset     = r_offset;
        n_count      = r_count;
        n_hdr_lo     = r_hdr_lo;
        n_held       = r_held;
        n_flags      = r_flags;
        n_out_byte   = in_byte;
        n_out_status = nusf_pkg::STATUS_OK;
        wr_check_lo  = 1'b0;
        wr_check_hi  = 1'b0;
        wr_data_lo   = 1'b0;
        wr_data_hi   = 1'b0;
        in_tail      = 1'b0;
        tail_fixed   = 1'b0;
        tail_ready   = 1'b0;

        // Header fields arrive low byte first.
        if (r_pos == PW'(nusf_pkg::HDR_OFFSET_LO) || r_pos == PW'(nusf_pkg::HDR_COUNT_LO)) begin
            n_hdr_lo = in_byte;
        end else if (r_pos == PW'(nusf_pkg::HDR_OFFSET_HI)) begin
            n_offset = hdr_word;
        end else if (r_pos == PW'(nusf_pkg::HDR_COUNT_HI)) begin
            n_count = hdr_word;
            if (offset_w < CW'(nusf_pkg::HDR_BYTES)
                    || offset_w + CW'(2) > size_w || hdr_word == '0) begin
                n_flags[nusf_pkg::FLAG_BAD_HDR] = 1'b1;
            end
        end

        active = (r_pos >= PW'(nusf_pkg::HDR_BYTES)) && !r_flags[nusf_pkg::FLAG_BAD_HDR];

        // Keep the fixup array words as they pass.
        if (active && pos_w >= offset_w && word_k < count_w
                && word_k < CW'(WORD_SLOTS)) begin
            if (word_k == '0) begin
                wr_check_lo = !arr_dist[0];
                wr_check_hi = arr_dist[0];
            end else begin
                wr_data_lo = !arr_dist[0];
                wr_data_hi = arr_dist[0];
            end
        end

        // Sector tails that lie inside the record and have an array entry.
        in_tail    = r_sec_pos >= SPW'(SECTOR_BYTES - 2);
        tail_fixed = active && in_tail
                     && (sec_start + CW'(SECTOR_BYTES) <= size_w)
                     && (slot_w < count_w);
        tail_ready = (r_count != '0) && (offset_w + CW'(1) < first_tail)
                     && (slot_w < CW'(WORD_SLOTS))
                     && (offset_w + (slot_w << 1) + CW'(1) < first_tail);
        if (tail_fixed) begin
            if (r_sec_pos == SPW'(SECTOR_BYTES - 2)) begin
                if (tail_ready) begin
                    n_held     = in_byte;
                    n_out_byte = tail_word[7:0];
                end else begin
                    n_flags[nusf_pkg::FLAG_UNSEEN] = 1'b1;
                end
            end else if (tail_ready) begin
                if ({in_byte, r_held} != r_check) begin
                    n_flags[nusf_pkg::FLAG_MISMATCH] = 1'b1;
                end
                n_out_byte = tail_word[15:8];
            end
        end

        // Record end: report status and start over.
        rec_end   = pos_w + CW'(1) >= size_w;
        n_out_end = rec_end;
        if (rec_end) begin
            if (r_pos < PW'(nusf_pkg::HDR_COUNT_HI)) begin
                n_flags[nusf_pkg::FLAG_BAD_HDR] = 1'b1;
            end
            if (n_flags[nusf_pkg::FLAG_BAD_HDR]) begin
                n_out_status = nusf_pkg::STATUS_BAD_HDR;
            end else if (n_flags[nusf_pkg::FLAG_UNSEEN]) begin
                n_out_status = nusf_pkg::STATUS_UNSEEN;
            end else if (n_flags[nusf_pkg::FLAG_MISMATCH]) begin
                n_out_status = nusf_pkg::STATUS_MISMATCH;
            end
            n_pos     = '0;
            n_sec_pos = '0;
            n_sec_idx = '0;
            n_offset  = '0;
            n_count   = '0;
            n_hdr_lo  = '0;
            n_held    = '0;
            n_flags   = '0;
        end else begin
            n_pos = r_pos + PW'(1);
            if (r_sec_pos == SPW'(SECTOR_BYTES - 1)) begin
                n_sec_pos = '0;
                n_sec_idx = r_sec_idx + SIW'(1);
            end else begin
                n_sec_pos = r_sec_pos + SPW'(1);
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_size <= nusf_pkg::RECORD_SIZE_RESET;
            r_pos         <= '0;
            r_sec_pos     <= '0;
            r_sec_idx     <= '0;
            r_offset      <= '0;
            r_count       <= '0;
            r_hdr_lo      <= '0;
            r_held        <= '0;
            r_flags       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_record_size <= pwdata[nusf_pkg::CFG_W-1:0];
            end
            if (accept) begin
                r_pos       <= n_pos;
                r_sec_pos   <= n_sec_pos;
                r_sec_idx   <= n_sec_idx;
                r_offset    <= n_offset;
                r_count     <= n_count;
                r_hdr_lo    <= n_hdr_lo;
                r_held      <= n_held;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: result byte and fixup array.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte   <= n_out_byte;
            r_out_end    <= n_out_end;
            r_out_status <= n_out_status;
            if (wr_check_lo) begin
                r_check[7:0] <= in_byte;
            end
            if (wr_check_hi) begin
                r_check[15:8] <= in_byte;
            end
            if (wr_data_lo) begin
                r_words[wr_idx][7:0] <= in_byte;
            end
            if (wr_data_hi) begin
                r_words[wr_idx][15:8] <= in_byte;
            end
        end
    end

`ifndef SYNTHESIS
    // A non-zero status only ever travels with the last byte of a record.
    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_end) |-> (r_out_status == nusf_pkg::STATUS_OK))
        else $error("status set on a byte that does not end the record");

    // The byte after a record end starts a fresh record.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_out_end) |=> (r_pos == '0 && r_sec_pos == '0 && r_flags == '0))
        else $error("record state not cleared after record end");

    // The input never stalls while the output register is free.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || o_result.ready) |-> i_data.ready)
        else $error("input stalled with a free output register");

    // The byte position advances on each accepted byte that does not end a record.
    a_sector_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !n_out_end) |=> (r_pos == $past(r_pos) + PW'(1)))
        else $error("byte position did not advance");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAX_RECORD_BYTES = 4096;
    localparam int SECTOR_BYTES     = 512;
    localparam int WORD_SLOTS       = MAX_RECORD_BYTES / SECTOR_BYTES + 1;
    localparam int MAX_WAIT         = 8;
    localparam int STALL_LIMIT      = 2000;

    // Shapes of generated records.
    typedef enum int {
        REC_CLEAN,
        REC_TAIL_MISMATCH,
        REC_LATE_ARRAY,
        REC_SHORT_COUNT,
        REC_LONG_COUNT,
        REC_BAD_HEADER,
        REC_NOISE
    } t_rec_kind;

    typedef struct packed {
        nusf_pkg::t_byte   out_byte;
        logic              record_end;
        nusf_pkg::t_status status;
    } t_fixed_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic rst_done;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [nusf_pkg::APB_AW-1:0]   paddr;
    logic [nusf_pkg::APB_DW-1:0]   pwdata;
    logic [nusf_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    nusf_in_if  byte_in ();
    nusf_out_if byte_out ();

    ntfs_update_sequence_fixup_core #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
        .SECTOR_BYTES    (SECTOR_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (byte_in),
        .o_result(byte_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Raw record bytes waiting to be sent and fixed-up bytes still owed by the block.
    nusf_pkg::t_byte raw_bytes_q[$];
    t_fixed_byte     fixed_bytes_q[$];

    int unsigned err_cnt;
    int unsigned stall_cnt;
    logic        in_taken;
    logic        out_taken;
    int unsigned in_gap;
    int unsigned out_wait;
    logic        in_burst;
    logic        out_burst;

    // Shadow of the record_size register and of the per-record fixup state.
    logic [nusf_pkg::CFG_W-1:0] cfg_record_size;
    int unsigned                rec_pos;
    int unsigned                arr_off;
    int unsigned                arr_cnt;
    nusf_pkg::t_word            fx_words[WORD_SLOTS];
    nusf_pkg::t_byte            held_tail;
    nusf_pkg::t_byte            hdr_lo;
    nusf_pkg::t_flags           rec_flags;

    function automatic int unsigned clamped_size();
        int unsigned sz;
        sz = cfg_record_size;
        if (sz < nusf_pkg::MIN_RECORD_BYTES) sz = nusf_pkg::MIN_RECORD_BYTES;
        if (sz > MAX_RECORD_BYTES) sz = MAX_RECORD_BYTES;
        return sz;
    endfunction

    // A fixup word counts only if both of its bytes passed before the sector tail.
    function automatic bit word_arrived(input int unsigned k, input int unsigned first_tail);
        return k < WORD_SLOTS && k < arr_cnt && arr_off + 2 * k + 1 < first_tail;
    endfunction

    function automatic void clear_record();
        rec_pos   = 0;
        arr_off   = 0;
        arr_cnt   = 0;
        held_tail = '0;
        hdr_lo    = '0;
        rec_flags = '0;
    endfunction

    // Works out the fixed-up copy of one raw byte and queues it.
    function automatic void fixup_byte(input nusf_pkg::t_byte b);
        int unsigned p;
        int unsigned sz;
        int unsigned in_sec;
        int unsigned d;
        int unsigned k;
        int unsigned sec;
        int unsigned first_tail;
        bit          rdy;
        t_fixed_byte want;
        p    = rec_pos;
        sz   = clamped_size();
        want = '{out_byte: b, record_end: 1'b0, status: nusf_pkg::STATUS_OK};

        // Header fields are little-endian 16-bit words.
        if (p == nusf_pkg::HDR_OFFSET_LO || p == nusf_pkg::HDR_COUNT_LO) begin
            hdr_lo = b;
        end else if (p == nusf_pkg::HDR_OFFSET_HI) begin
            arr_off = {b, hdr_lo};
        end else if (p == nusf_pkg::HDR_COUNT_HI) begin
            arr_cnt = {b, hdr_lo};
            if (arr_off < nusf_pkg::HDR_BYTES || arr_off + 2 > sz || arr_cnt == 0)
                rec_flags[nusf_pkg::FLAG_BAD_HDR] = 1'b1;
        end

        if (p >= nusf_pkg::HDR_BYTES && !rec_flags[nusf_pkg::FLAG_BAD_HDR]) begin
            in_sec = p % SECTOR_BYTES;
            // Capture array words as they pass.
            if (p >= arr_off) begin
                d = p - arr_off;
                k = d >> 1;
                if (k < arr_cnt && k < WORD_SLOTS) begin
                    if (d[0] == 1'b0) fx_words[k][7:0] = b;
                    else              fx_words[k][15:8] = b;
                end
            end
            // Restore the two tail bytes of a full sector that has an entry.
            if (in_sec >= SECTOR_BYTES - 2) begin
                sec = p / SECTOR_BYTES;
                if ((sec + 1) * SECTOR_BYTES <= sz && sec + 1 < arr_cnt) begin
                    first_tail = p - (in_sec - (SECTOR_BYTES - 2));
                    rdy = word_arrived(0, first_tail) && word_arrived(sec + 1, first_tail);
                    if (in_sec == SECTOR_BYTES - 2) begin
                        if (rdy) begin
                            held_tail     = b;
                            want.out_byte = fx_words[sec + 1][7:0];
                        end else begin
                            rec_flags[nusf_pkg::FLAG_UNSEEN] = 1'b1;
                        end
                    end else if (rdy) begin
                        if ({b, held_tail} != fx_words[0])
                            rec_flags[nusf_pkg::FLAG_MISMATCH] = 1'b1;
                        want.out_byte = fx_words[sec + 1][15:8];
                    end
                end
            end
        end

        if (p + 1 >= sz) begin
            if (p < nusf_pkg::HDR_COUNT_HI) rec_flags[nusf_pkg::FLAG_BAD_HDR] = 1'b1;
            want.record_end = 1'b1;
            if (rec_flags[nusf_pkg::FLAG_BAD_HDR])
                want.status = nusf_pkg::STATUS_BAD_HDR;
            else if (rec_flags[nusf_pkg::FLAG_UNSEEN])
                want.status = nusf_pkg::STATUS_UNSEEN;
            else if (rec_flags[nusf_pkg::FLAG_MISMATCH])
                want.status = nusf_pkg::STATUS_MISMATCH;
            clear_record();
        end else begin
            rec_pos = p + 1;
        end
        fixed_bytes_q.push_back(want);
    endfunction

    // Sampling at the rising edge: record input transactions, check output ones.
    always @(posedge i_clk) begin
        t_fixed_byte want;
        t_fixed_byte got;
        in_taken  <= byte_in.valid && byte_in.ready;
        out_taken <= byte_out.valid && byte_out.ready;

        if (rst_done && byte_in.valid && byte_in.ready)
            fixup_byte(byte_in.data_byte);

        if (rst_done && byte_out.valid && byte_out.ready) begin
            got = '{out_byte: byte_out.out_byte, record_end: byte_out.record_end,
                    status: byte_out.status};
            if (fixed_bytes_q.size() == 0) begin
                $display("%0t ns: unexpected output byte %02h (end %0b status %0d)",
                         $time, got.out_byte, got.record_end, got.status);
                err_cnt++;
            end else begin
                want = fixed_bytes_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t ns: out_byte expected %02h actual %02h",
                             $time, want.out_byte, got.out_byte);
                    err_cnt++;
                end
                if (got.record_end !== want.record_end) begin
                    $display("%0t ns: record_end expected %0b actual %0b",
                             $time, want.record_end, got.record_end);
                    err_cnt++;
                end
                if (got.status !== want.status) begin
                    $display("%0t ns: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    err_cnt++;
                end
            end
        end

        // Watchdog on cycles without any transaction.
        if (rst_done) begin
            if ((byte_in.valid && byte_in.ready) || (byte_out.valid && byte_out.ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Byte driver: one pending byte per transaction, random gap between them.
    always @(negedge i_clk) begin
        if (!rst_done) begin
            byte_in.valid <= 1'b0;
        end else if (!byte_in.valid || in_taken) begin
            if (in_gap > 0) begin
                byte_in.valid <= 1'b0;
                in_gap        <= in_gap - 1;
            end else if (raw_bytes_q.size() > 0) begin
                byte_in.data_byte <= raw_bytes_q.pop_front();
                byte_in.valid     <= 1'b1;
                in_gap            <= in_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 63) == 0) in_burst <= !in_burst;
            end else begin
                byte_in.valid <= 1'b0;
            end
        end
    end

    // Output stall: after each transaction the receiver may hold ready low.
    always @(negedge i_clk) begin
        int unsigned w;
        if (!rst_done) begin
            byte_out.ready <= 1'b0;
        end else if (out_taken) begin
            w = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
            if (w > 0) begin
                byte_out.ready <= 1'b0;
                out_wait       <= w - 1;
            end else begin
                byte_out.ready <= 1'b1;
            end
        end else if (out_wait > 0) begin
            byte_out.ready <= 1'b0;
            out_wait       <= out_wait - 1;
        end else begin
            byte_out.ready <= 1'b1;
        end
    end

    // Waits at a falling edge until no byte is pending or owed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (raw_bytes_q.size() != 0 || byte_in.valid || fixed_bytes_q.size() != 0);
    endtask

    // APB write of record_size followed by a read-back; called at a falling edge.
    task automatic write_record_size(input logic [nusf_pkg::CFG_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {nusf_pkg::REG_RECORD_SIZE, 2'b00};
        pwdata  = nusf_pkg::APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_record_size = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (prdata !== nusf_pkg::APB_DW'(value)) begin
            $display("%0t ns: record_size read expected %0d actual %0d",
                     $time, value, prdata);
            err_cnt++;
        end
    endtask

    function automatic t_rec_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return REC_CLEAN;
        if (r < 58) return REC_TAIL_MISMATCH;
        if (r < 68) return REC_LATE_ARRAY;
        if (r < 76) return REC_SHORT_COUNT;
        if (r < 84) return REC_LONG_COUNT;
        if (r < 92) return REC_BAD_HEADER;
        return REC_NOISE;
    endfunction

    // Builds one record of the given size and queues its bytes.
    task automatic build_record(input int unsigned size, input t_rec_kind kind);
        nusf_pkg::t_byte rec[];
        int unsigned     n_sec;
        int unsigned     cnt;
        int unsigned     hdr_cnt;
        int unsigned     off;
        int unsigned     hi_off;
        int unsigned     k;
        nusf_pkg::t_word chk;
        nusf_pkg::t_word w;
        rec = new[size];
        foreach (rec[i]) rec[i] = nusf_pkg::t_byte'($urandom);
        n_sec = size / SECTOR_BYTES;
        chk   = nusf_pkg::t_word'($urandom);
        if (n_sec > 0) cnt = n_sec + 1;
        else           cnt = (size >= 14) ? $urandom_range(1, 3) : 1;

        // Normally every array word is complete before the first sector tail.
        hi_off = ((n_sec > 0) ? SECTOR_BYTES - 2 : size) - 2 * cnt;
        off    = $urandom_range(nusf_pkg::HDR_BYTES, hi_off);
        if (kind == REC_LATE_ARRAY && n_sec > 0) begin
            hi_off = (SECTOR_BYTES + 8 > size - 2) ? size - 2 : SECTOR_BYTES + 8;
            off    = $urandom_range(SECTOR_BYTES - 12, hi_off);
        end

        for (k = 0; k < cnt; k++) begin
            w = (k == 0) ? chk : nusf_pkg::t_word'($urandom);
            if (off + 2 * k + 1 < size) begin
                rec[off + 2 * k]     = w[7:0];
                rec[off + 2 * k + 1] = w[15:8];
            end
        end
        for (k = 0; k < n_sec; k++) begin
            rec[k * SECTOR_BYTES + SECTOR_BYTES - 2] = chk[7:0];
            rec[k * SECTOR_BYTES + SECTOR_BYTES - 1] = chk[15:8];
        end
        hdr_cnt = cnt;

        case (kind)
            REC_TAIL_MISMATCH: begin
                if (n_sec > 0) begin
                    k = $urandom_range(0, n_sec - 1) * SECTOR_BYTES + SECTOR_BYTES - 2
                        + $urandom_range(0, 1);
                    rec[k] = rec[k] ^ nusf_pkg::t_byte'(1 << $urandom_range(0, 7));
                end
            end
            REC_SHORT_COUNT: begin
                if (n_sec > 0) hdr_cnt = $urandom_range(1, n_sec);
            end
            REC_LONG_COUNT: begin
                hdr_cnt = ($urandom_range(0, 3) == 0) ? 16'hFFFF : cnt + $urandom_range(1, 20);
            end
            REC_BAD_HEADER: begin
                case ($urandom_range(0, 2))
                    0: off = $urandom_range(0, nusf_pkg::HDR_BYTES - 1);
                    1: off = $urandom_range(size - 1, 16'hFFFF);
                    default: hdr_cnt = 0;
                endcase
            end
            default: ;
        endcase

        if (kind != REC_NOISE) begin
            rec[nusf_pkg::HDR_OFFSET_LO] = off[7:0];
            rec[nusf_pkg::HDR_OFFSET_HI] = off[15:8];
            rec[nusf_pkg::HDR_COUNT_LO]  = hdr_cnt[7:0];
            rec[nusf_pkg::HDR_COUNT_HI]  = hdr_cnt[15:8];
        end
        foreach (rec[i]) raw_bytes_q.push_back(rec[i]);
    endtask

    // One register setting followed by a run of records at that size.
    task automatic run_phase(input int unsigned size, input int unsigned n_rec);
        t_rec_kind   kind;
        int unsigned r;
        wait_drained();
        write_record_size(nusf_pkg::CFG_W'(size));
        for (r = 0; r < n_rec; r++) begin
            kind = (size == MAX_RECORD_BYTES) ? REC_CLEAN : pick_kind();
            build_record(size, kind);
        end
    endtask

    // Main sequence: reset, directed records, then randomized phases.
    initial begin
        nusf_pkg::t_byte dir_ok[10];
        nusf_pkg::t_byte dir_low_off[10];
        int unsigned     ph;
        dir_ok            = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h08, 8'h00,
                              8'h01, 8'h00, 8'hFF, 8'h00};
        dir_low_off       = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h03, 8'h00,
                              8'h01, 8'h00, 8'h5A, 8'hA5};
        i_rst_n           = 1'b0;
        rst_done          = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = '0;
        byte_out.ready    = 1'b0;
        err_cnt           = 0;
        stall_cnt         = 0;
        in_taken          = 1'b0;
        out_taken         = 1'b0;
        in_gap            = 0;
        out_wait          = 0;
        in_burst          = 1'b0;
        out_burst         = 1'b0;
        cfg_record_size   = nusf_pkg::RECORD_SIZE_RESET;
        foreach (fx_words[i]) fx_words[i] = '0;
        clear_record();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        // Smallest record: a size below the minimum is clamped to two bytes,
        // so the record ends before the header is complete.
        write_record_size('0);
        raw_bytes_q.push_back(8'h00);
        raw_bytes_q.push_back(8'hFF);

        // Ten-byte records: a valid header with no full sector, then an offset below 8.
        wait_drained();
        write_record_size(nusf_pkg::CFG_W'(10));
        foreach (dir_ok[i]) raw_bytes_q.push_back(dir_ok[i]);
        foreach (dir_low_off[i]) raw_bytes_q.push_back(dir_low_off[i]);

        // Random records: one spanning two full sectors, then short ones.
        run_phase($urandom_range(2 * SECTOR_BYTES, 2 * SECTOR_BYTES + 100), 1);
        for (ph = 0; ph < 4; ph++)
            run_phase($urandom_range(10, 64), 2);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> ntfs_update_sequence_fixup_core.f
design/nusf_pkg.sv
design/nusf_in_if.sv
design/nusf_out_if.sv
design/ntfs_update_sequence_fixup_core.sv
tb/tb.sv
